FILE: src/ots_pkg.sv
// ----------------------------------------------------------------------------
// ots_pkg
// Types, codes and default sizes shared by the offset to segment sweep block.
// ----------------------------------------------------------------------------
package ots_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 48;
  localparam int STATUS_W = 2;
  localparam int SEG_W    = 11;
  localparam int OFF_W    = 32;

  localparam int DEF_MAX_SEGMENTS = 1024;
  localparam int DEF_SIZE_BITS    = 32;
  localparam int DEF_POS_BITS     = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BEYOND = 2'd2,
    STATUS_BELOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_DONE  = 2'd2
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [SEG_W-1:0]   segment_number;
    logic [OFF_W-1:0]   offset_in_segment;
  } out_word_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: src/ots_size_mem.sv
// ----------------------------------------------------------------------------
// ots_size_mem
// Segment size memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ots_size_mem
  import ots_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  parameter int WIDTH = DEF_SIZE_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_ctl_t         mem_ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ots_sweep.sv
// ----------------------------------------------------------------------------
// ots_sweep
// Sweep engine: appends sizes, clears the table, advances the sweep pointer one
// segment per cycle through the size memory and forms the result word.
// ----------------------------------------------------------------------------
module ots_sweep
  import ots_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int SIZE_BITS    = DEF_SIZE_BITS,
  parameter int POS_BITS     = DEF_POS_BITS,
  parameter int IDX_W        = $clog2(MAX_SEGMENTS),
  parameter int CNT_W        = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 res_valid,
  output out_word_t            res_word,
  input  logic                 res_take,
  output mem_ctl_t             mem_ctl,
  output logic [IDX_W-1:0]     mem_wr_addr,
  output logic [SIZE_BITS-1:0] mem_wr_data,
  output logic [IDX_W-1:0]     mem_rd_addr,
  input  logic [SIZE_BITS-1:0] mem_rd_data
);

  localparam int CMP_W = (POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [POS_BITS-1:0] sum_r, sum_nxt;
  logic [POS_BITS-1:0] rem_r, rem_nxt;
  out_word_t           res_r, res_nxt;

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] pos_diff;
  logic                pos_above;
  logic                table_full;
  logic                sweep_at_end;
  logic [CNT_W-1:0]    idx_inc;
  logic                inside_seg;
  logic [POS_BITS-1:0] size_pos;
  logic                accept;

  assign accept       = in_valid && (state_r == ST_IDLE);
  assign pos          = POS_BITS'(in_word.value);
  assign pos_diff     = pos - sum_r;
  assign pos_above    = pos > sum_r;
  assign table_full   = count_r == CNT_W'(MAX_SEGMENTS);
  assign sweep_at_end = idx_r >= count_r;
  assign idx_inc      = idx_r + CNT_W'(1);
  assign inside_seg   = CMP_W'(rem_r) <= CMP_W'(mem_rd_data);
  assign size_pos     = POS_BITS'(mem_rd_data);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DONE;
          res_nxt   = '{STATUS_OK, '0, '0};
          unique case (in_word.kind)
            KIND_APPEND: begin
              if (table_full) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              if (!pos_above) begin
                res_nxt.status = STATUS_BELOW;
              end else if (sweep_at_end) begin
                res_nxt.status = STATUS_BEYOND;
              end else begin
                rem_nxt   = pos_diff;
                state_nxt = ST_CHECK;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
              idx_nxt   = '0;
              sum_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (inside_seg) begin
          res_nxt   = '{STATUS_OK, SEG_W'(idx_inc), OFF_W'(rem_r)};
          state_nxt = ST_DONE;
        end else begin
          sum_nxt = sum_r + size_pos;
          rem_nxt = rem_r - size_pos;
          idx_nxt = idx_inc;
          if (idx_inc >= count_r) begin
            res_nxt   = '{STATUS_BEYOND, '0, '0};
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    res_valid     = state_r == ST_DONE;
    res_word      = res_r;
    mem_ctl.wr_en = accept && (in_word.kind == KIND_APPEND) && !table_full;
    mem_ctl.rd_en = 1'b0;
    mem_wr_addr   = count_r[IDX_W-1:0];
    mem_wr_data   = SIZE_BITS'(in_word.value);
    mem_rd_addr   = idx_r[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        mem_ctl.rd_en = accept && (in_word.kind == KIND_QUERY);
      end
      ST_CHECK: begin
        mem_ctl.rd_en = !inside_seg;
        mem_rd_addr   = idx_inc[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

endmodule

FILE: src/offset_to_segment_sweep.sv
// ----------------------------------------------------------------------------
// offset_to_segment_sweep
// Maps a 1-based global position onto a segment number and an offset inside
// it, using a table of appended segment sizes and a forward-only sweep.
//
//   port group   dir   word type    meaning
//   in_*         in    in_word_t    append size, query position or clear
//   out_*        out   out_word_t   status, segment number, offset
//
// Appends, clears and queries that need no table read go from idle straight to done.
// A query that reads the table stays in the check state for each entry read,
// as the size memory delivers one entry per cycle on its single read port.
// Reset is synchronous and empties the table and sweep; no clearing pass.
// A result waits in the output register while out_stall is high, and the
// engine accepts the next word meanwhile but holds its own result until then.
// ----------------------------------------------------------------------------
module offset_to_segment_sweep
  import ots_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int SIZE_BITS    = DEF_SIZE_BITS,
  parameter int POS_BITS     = DEF_POS_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  mem_ctl_t             mem_ctl;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [SIZE_BITS-1:0] mem_wr_data;
  logic [SIZE_BITS-1:0] mem_rd_data;

  logic      res_valid;
  out_word_t res_word;
  logic      res_take;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  ots_sweep #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS),
    .POS_BITS     (POS_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .res_valid   (res_valid),
    .res_word    (res_word),
    .res_take    (res_take),
    .mem_ctl     (mem_ctl),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ots_size_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: src/ots_checker.sv
// ----------------------------------------------------------------------------
// ots_checker
// Port-level checks for the offset to segment sweep, bound to the top level.
// ----------------------------------------------------------------------------
module ots_checker
  import ots_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // The engine works on one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

  // Error results carry no segment or offset.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != STATUS_OK) |->
      (out_word.segment_number == '0) && (out_word.offset_in_segment == '0))
    else $error("error result with nonzero segment or offset");

endmodule

bind offset_to_segment_sweep ots_checker u_ots_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
